@@ rtl/rcd_pkg.sv @@
package rcd_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 6;
   localparam int REM_W   = COUNT_W + 1;
   localparam int CNT_W   = 2;

   // chunk types, header bits 7..6
   localparam logic [1:0] TYPE_FILL = 2'd0;
   localparam logic [1:0] TYPE_BYTE = 2'd1;
   localparam logic [1:0] TYPE_PAIR = 2'd2;
   localparam logic [1:0] TYPE_LIT  = 2'd3;

   localparam logic [CNT_W-1:0] COUNT_ONE = 2'd1;
   localparam logic [CNT_W-1:0] COUNT_TWO = 2'd2;

   localparam int RSP_DATA_W = 24;

   typedef struct packed {
      logic hdr;       // take header byte
      logic first;     // take repeated byte or first pair byte
      logic second;    // take second pair byte
      logic emit_run;  // push one run word
      logic emit_lit;  // push incoming byte as a literal word
   } rcd_cmd_type;

   typedef struct packed {
      logic [1:0] in_type;     // type field of the incoming byte
      logic [1:0] chunk_type;  // type of the chunk in progress
      logic       last;        // one word left in the chunk
      logic       load_ok;     // output register can take a word
   } rcd_sts_type;

endpackage

@@ rtl/rcd_ctrl.sv @@
module rcd_ctrl
   import rcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  rcd_sts_type sts,
   output rcd_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_HEAD,
      ST_BYTE1,
      ST_BYTE2,
      ST_RUN,
      ST_LIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         ST_HEAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.hdr = 1'b1;
               case (sts.in_type)
                  TYPE_FILL: state_in = ST_RUN;
                  TYPE_LIT:  state_in = ST_LIT;
                  default:   state_in = ST_BYTE1;
               endcase
            end
         end
         ST_BYTE1: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.first = 1'b1;
               state_in  = (sts.chunk_type == TYPE_PAIR) ? ST_BYTE2 : ST_RUN;
            end
         end
         ST_BYTE2: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.second = 1'b1;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.load_ok) begin
               cmd.emit_run = 1'b1;
               if (sts.last) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_LIT: begin
            req_tready = sts.load_ok;
            if (req_tvalid && sts.load_ok) begin
               cmd.emit_lit = 1'b1;
               if (sts.last) begin
                  state_in = ST_HEAD;
               end
            end
         end
         default: begin
            state_in = ST_HEAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/rcd_dp.sv @@
module rcd_dp
   import rcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [BYTE_W-1:0]     csr_wdata,
   input  logic [BYTE_W-1:0]     in_byte,
   input  rcd_cmd_type           cmd,
   output rcd_sts_type           sts,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [BYTE_W-1:0]     out_byte_a,
   output logic [BYTE_W-1:0]     out_byte_b,
   output logic [CNT_W-1:0]      byte_count,
   output logic                  run_last
);

   logic [BYTE_W-1:0] fill_ff;
   logic [1:0]        type_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [BYTE_W-1:0] a_ff, b_ff;
   logic              two_ff;

   logic              ovalid_ff, ovalid_in;
   logic [BYTE_W-1:0] oa_ff, ob_ff;
   logic [CNT_W-1:0]  ocnt_ff;
   logic              olast_ff;

   logic              last;
   logic              load_ok;
   logic              emit;

   assign last    = (rem_ff == REM_W'(1));
   assign load_ok = !ovalid_ff || rsp_tready;
   assign emit    = cmd.emit_run || cmd.emit_lit;

   assign sts.in_type    = in_byte[BYTE_W-1 -: 2];
   assign sts.chunk_type = type_ff;
   assign sts.last       = last;
   assign sts.load_ok    = load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (csr_wen) begin
         fill_ff <= csr_wdata;
      end
   end

   // chunk registers; fill byte is captured when the header arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff <= TYPE_FILL;
         rem_ff  <= '0;
      end else begin
         if (cmd.hdr) begin
            type_ff <= in_byte[BYTE_W-1 -: 2];
            rem_ff  <= {1'b0, in_byte[COUNT_W-1:0]} + REM_W'(1);
         end else if (emit) begin
            rem_ff  <= rem_ff - REM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hdr) begin
         a_ff   <= fill_ff;
         b_ff   <= '0;
         two_ff <= 1'b0;
      end else if (cmd.first) begin
         a_ff   <= in_byte;
         b_ff   <= '0;
         two_ff <= 1'b0;
      end else if (cmd.second) begin
         b_ff   <= in_byte;
         two_ff <= 1'b1;
      end
   end

   // output register
   assign ovalid_in = emit || (ovalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_run) begin
         oa_ff    <= a_ff;
         ob_ff    <= b_ff;
         ocnt_ff  <= two_ff ? COUNT_TWO : COUNT_ONE;
         olast_ff <= last;
      end else if (cmd.emit_lit) begin
         oa_ff    <= in_byte;
         ob_ff    <= '0;
         ocnt_ff  <= COUNT_ONE;
         olast_ff <= last;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign out_byte_a = oa_ff;
   assign out_byte_b = ob_ff;
   assign byte_count = ocnt_ff;
   assign run_last   = olast_ff;

endmodule

@@ rtl/rle_chunk_decompressor.sv @@
// Run-length chunk decompressor. Compressed bytes enter one per word on req_;
// a header byte carries the chunk type in bits 7..6 and a count in bits 5..0
// (run length = count + 1). Type 0 repeats the csr fill byte, type 1 the next
// byte, type 2 the next two bytes as a pair, type 3 passes the following bytes
// through. Each rsp_ word holds one or two bytes, tlast marks a chunk's last
// word. Header and payload bytes are taken one per cycle; a run of length L
// then gives L words at one per cycle from the output register, during which
// no input is taken, so a run chunk takes its header, then no (type 0), one
// (type 1) or two (type 2) payload bytes, then gives its L words of output.
// Literal bytes pass at one per cycle. Output back-pressure stalls the run
// and the literal bytes cycle for cycle. The fill byte is sampled when a type
// 0 header is taken.
module rle_chunk_decompressor
   import rcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [BYTE_W-1:0]     csr_wdata,   // fill_byte
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] in_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] out_byte_a, [15:8] out_byte_b, [17:16] byte_count, [23:18] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast    // run_last
);

   rcd_cmd_type       cmd;
   rcd_sts_type       sts;
   logic [BYTE_W-1:0] out_byte_a, out_byte_b;
   logic [CNT_W-1:0]  byte_count;

   rcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rcd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .in_byte    (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .out_byte_a (out_byte_a),
      .out_byte_b (out_byte_b),
      .byte_count (byte_count),
      .run_last   (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - 2*BYTE_W - CNT_W)'(0), byte_count, out_byte_b, out_byte_a};

endmodule

@@ rtl/rcd_chk.sv @@
module rcd_chk
   import rcd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic [CNT_W-1:0] cnt;
   assign cnt = rsp_tdata[2*BYTE_W +: CNT_W];

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cnt == COUNT_ONE) || (cnt == COUNT_TWO))
      else $error("byte count out of range");

   // single-byte words keep the second lane clear
   a_lane_b: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (cnt == COUNT_ONE) |-> rsp_tdata[BYTE_W +: BYTE_W] == '0)
      else $error("second lane set on single-byte word");

   // padding above the byte count stays clear
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:2*BYTE_W+CNT_W] == '0)
      else $error("padding bits set");

endmodule

bind rle_chunk_decompressor rcd_chk u_rcd_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/tb_rle_chunk_decompressor.sv @@
`timescale 1ns / 1ps

module tb_rle_chunk_decompressor;
   import rcd_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int HOLD_CYCLES  = 240;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 90;

   // decoder states of the predictor
   localparam logic [1:0] ST_HEADER  = 2'd0;
   localparam logic [1:0] ST_FIRST   = 2'd1;
   localparam logic [1:0] ST_SECOND  = 2'd2;
   localparam logic [1:0] ST_LITERAL = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      logic [CNT_W-1:0]  nbytes;
      logic              last;
   } out_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [BYTE_W-1:0]     csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;   // [7:0] in_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [7:0] a, [15:8] b, [17:16] byte_count
   logic                  rsp_tlast;

   logic [BYTE_W-1:0] comp_bytes[$];
   out_word_type      pending_words[$];

   // predictor state
   logic [BYTE_W-1:0] fill_model = '0;
   logic [1:0]        dec_state = ST_HEADER;
   logic [1:0]        dec_type = TYPE_FILL;
   logic [REM_W-1:0]  dec_left = '0;
   logic [BYTE_W-1:0] dec_pair = '0;

   int  hdr_seen[4] = '{0, 0, 0, 0};
   int  bytes_in = 0;
   int  words_checked = 0;
   int  mismatches = 0;
   int  fill_writes = 0;
   int  cycle_count = 0;
   int  src_gap = 0;
   int  sink_gap = 0;
   int  hold_cnt = 0;
   bit  hold_arm = 1'b0;
   bit  hold_done = 1'b0;
   bit  idle_on = 1'b1;

   rle_chunk_decompressor i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   task automatic push_run(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                           input logic [CNT_W-1:0] cnt, input logic [REM_W-1:0] len);
      out_word_type w;
      int k;
      for (k = 0; k < int'(len); k++) begin
         w.lo     = a;
         w.hi     = (cnt == COUNT_TWO) ? b : '0;
         w.nbytes = cnt;
         w.last   = (k == int'(len) - 1);
         pending_words.push_back(w);
      end
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      out_word_type w;
      case (dec_state)
         ST_HEADER: begin
            dec_type = b[7:6];
            dec_left = {1'b0, b[COUNT_W-1:0]} + 1'b1;
            hdr_seen[dec_type]++;
            if (dec_type == TYPE_FILL) begin
               push_run(fill_model, '0, COUNT_ONE, dec_left);
               dec_left = '0;
            end else if (dec_type == TYPE_LIT) begin
               dec_state = ST_LITERAL;
            end else begin
               dec_state = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (dec_type == TYPE_PAIR) begin
               dec_pair  = b;
               dec_state = ST_SECOND;
            end else begin
               push_run(b, '0, COUNT_ONE, dec_left);
               dec_left  = '0;
               dec_state = ST_HEADER;
            end
         end
         ST_SECOND: begin
            push_run(dec_pair, b, COUNT_TWO, dec_left);
            dec_left  = '0;
            dec_state = ST_HEADER;
         end
         default: begin
            dec_left = dec_left - 1'b1;
            w.lo     = b;
            w.hi     = '0;
            w.nbytes = COUNT_ONE;
            w.last   = (dec_left == 0);
            pending_words.push_back(w);
            if (dec_left == 0) dec_state = ST_HEADER;
         end
      endcase
   endtask

   // well-formed chunks with random content, a tenth stray bytes; chunks may be
   // cut short at the end of a phase and carry on as payload of the next
   task automatic queue_stream(input int n);
      int left;
      int npay;
      int k;
      logic [1:0] ct;
      logic [COUNT_W-1:0] cnt;
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            comp_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            left--;
         end else begin
            ct  = 2'($urandom_range(0, 3));
            cnt = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 63))
                                              : COUNT_W'($urandom_range(0, 7));
            comp_bytes.push_back({ct, cnt});
            left--;
            case (ct)
               TYPE_BYTE: npay = 1;
               TYPE_PAIR: npay = 2;
               TYPE_LIT:  npay = int'(cnt) + 1;
               default:   npay = 0;
            endcase
            for (k = 0; k < npay && left > 0; k++) begin
               comp_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
               left--;
            end
         end
      end
   endtask

   task automatic wait_idle();
      // a header that waits for payload gives no word, so allow the block to settle, then look again
      do begin
         while (comp_bytes.size() != 0 || req_tvalid || pending_words.size() != 0)
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end while (comp_bytes.size() != 0 || req_tvalid || pending_words.size() != 0);
   endtask

   task automatic write_fill(input logic [BYTE_W-1:0] v);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      fill_model = v;
      fill_writes++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata);
            bytes_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (src_gap != 0) begin
               src_gap    <= src_gap - 1;
               req_tvalid <= 1'b0;
            end else if (idle_on && comp_bytes.size() != 0 && $urandom_range(0, 9) == 0) begin
               src_gap    <= $urandom_range(0, 10);
               req_tvalid <= 1'b0;
            end else if (comp_bytes.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= comp_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      out_word_type got;
      out_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap   <= 0;
         hold_cnt   <= 0;
         hold_done  <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.lo     = rsp_tdata[7:0];
            got.hi     = rsp_tdata[15:8];
            got.nbytes = rsp_tdata[17:16];
            got.last   = rsp_tlast;
            if (pending_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected word a=%h b=%h n=%0d last=%b", $realtime,
                           got.lo, got.hi, got.nbytes, got.last);
            end else begin
               want = pending_words.pop_front();
               words_checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: word %0d exp %h/%h n=%0d l=%b, got %h/%h n=%0d l=%b",
                              $realtime, words_checked, want.lo, want.hi, want.nbytes,
                              want.last, got.lo, got.hi, got.nbytes, got.last);
               end
            end
         end
         if (hold_arm && !hold_done) begin
            hold_cnt   <= HOLD_CYCLES;
            hold_done  <= 1'b1;
            rsp_tready <= 1'b0;
         end else if (hold_cnt != 0) begin
            hold_cnt   <= hold_cnt - 1;
            rsp_tready <= 1'b0;
         end else if (sink_gap != 0) begin
            sink_gap   <= sink_gap - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_gap   <= $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_words.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [BYTE_W-1:0] fills[5];
      int p;
      fills = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'hFF};
      fills[2] = BYTE_W'($urandom_range(0, 255));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // extremes of each chunk type but the longest literal, fill byte still at its reset value
      comp_bytes = '{ {TYPE_FILL, 6'd0}, {TYPE_FILL, 6'h3F},
                      {TYPE_BYTE, 6'd0}, 8'hFF, {TYPE_BYTE, 6'h3F}, 8'h00,
                      {TYPE_PAIR, 6'd0}, 8'hA5, 8'h5A,
                      {TYPE_PAIR, 6'h3F}, 8'hFF, 8'h00,
                      {TYPE_LIT, 6'd0}, 8'h3C,
                      {TYPE_LIT, 6'd2}, 8'hFF, 8'h00, 8'h81 };
      wait_idle();

      for (p = 0; p < 5; p++) begin
         write_fill(fills[p]);
         if (p == 4) idle_on = 1'b0;
         queue_stream(PHASE_BYTES);
         // long output stall while input keeps coming
         if (p == 1) hold_arm = 1'b1;
         wait_idle();
      end

      $display("Sent %0d compressed bytes, checked %0d words over %0d fill settings",
               bytes_in, words_checked, fill_writes + 1);
      $display("Headers by type: fill %0d, byte %0d, pair %0d, literal %0d",
               hdr_seen[TYPE_FILL], hdr_seen[TYPE_BYTE], hdr_seen[TYPE_PAIR],
               hdr_seen[TYPE_LIT]);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d words never seen", mismatches, pending_words.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rcd_pkg.sv
rtl/rcd_ctrl.sv
rtl/rcd_dp.sv
rtl/rle_chunk_decompressor.sv
rtl/rcd_chk.sv
tb/tb_rle_chunk_decompressor.sv
